FILE: hw/rtl/melody_string_parser_unit_macros.svh
// Assertion macros for the melody string parser unit.
// Used by the RTL files that carry concurrent assertions; clocked on clk_i, reset by rst_ni.
`ifndef MELODY_STRING_PARSER_UNIT_MACROS_SVH
`define MELODY_STRING_PARSER_UNIT_MACROS_SVH

`ifndef SYNTH

// Checks that prop holds at every rising clock edge outside reset.
`define MSPU_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that post holds in the cycle after pre.
`define MSPU_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`else

`define MSPU_ASSERT(name, prop, msg)
`define MSPU_ASSERT_NEXT(name, pre, post, msg)

`endif

`endif

FILE: hw/rtl/mspu_pkg.sv
// Shared types and constants of the melody string parser unit.
// Depends on nothing; used by the top level.
`default_nettype none

package mspu_pkg;

  // Result kinds.
  localparam logic [1:0] KIND_NOTE  = 2'd0;
  localparam logic [1:0] KIND_END   = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // Note numbers.
  localparam logic [3:0] NOTE_NONE  = 4'd0;
  localparam logic [3:0] NOTE_C     = 4'd1;
  localparam logic [3:0] NOTE_D     = 4'd3;
  localparam logic [3:0] NOTE_E     = 4'd5;
  localparam logic [3:0] NOTE_F     = 4'd6;
  localparam logic [3:0] NOTE_G     = 4'd8;
  localparam logic [3:0] NOTE_A     = 4'd10;
  localparam logic [3:0] NOTE_B     = 4'd12;
  localparam logic [3:0] NOTE_PAUSE = 4'd13;

  localparam logic [7:0] PAUSE_CODE  = 8'd144;
  localparam logic [7:0] OCTAVE_STEP = 8'd24;

  // Effect codes.
  localparam logic [1:0] EFFECT_NONE  = 2'd0;
  localparam logic [1:0] EFFECT_PLUS  = 2'd1;
  localparam logic [1:0] EFFECT_MINUS = 2'd2;
  localparam logic [1:0] EFFECT_EQUAL = 2'd3;

  // Result queue depth; a character may produce two results.
  localparam int unsigned RES_DEPTH = 4;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] param_byte;
    logic [7:0] note_code;
    logic       last;
  } result_t;

endpackage

`default_nettype wire

FILE: hw/rtl/mspu_char_if.sv
// Character input channel of the melody string parser unit.
// Carries valid, ready and one ASCII character; no dependencies.
`default_nettype none

interface mspu_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;

  modport source (output valid, output char_in, input ready);
  modport sink   (input valid, input char_in, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/mspu_result_if.sv
// Result output channel of the melody string parser unit.
// Carries valid, ready and one decoded result; no dependencies.
`default_nettype none

interface mspu_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] param_byte;
  logic [7:0] note_code;
  logic       last;

  modport source (output valid, output kind, output param_byte, output note_code,
                  output last, input ready);
  modport sink   (input valid, input kind, input param_byte, input note_code,
                  input last, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/melody_string_parser_unit.sv
// Top level of the melody string parser unit: character decoder and result queue.
// Depends on mspu_pkg, mspu_char_if, mspu_result_if and the assertion macro header.
//
//   Channel   | Dir | Transaction                 | Payload
//   ----------+-----+-----------------------------+----------------------------------
//   char_i    | in  | one ASCII melody character  | char_in[7:0]
//   result_o  | out | one decoded result          | kind, param_byte, note_code, last
//
// A character is decoded in the cycle it is accepted, and its results are written
// into a four-entry result queue, so results appear on result_o only from the cycle after acceptance.
// One character per cycle is taken while the queue holds at most two results.
// A note closed without an effect mark by an end mark or a bad character yields two
// results; that is why two entries are kept free.
// Reset returns the parser to expecting an octave digit and empties the queue.
// A stall on result_o drops char_i.ready once the queue holds more than two results; nothing is lost.
`default_nettype none
`include "melody_string_parser_unit_macros.svh"

module melody_string_parser_unit
  import mspu_pkg::*;
#(
  parameter int unsigned Depth = RES_DEPTH
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  mspu_char_if.sink     char_i,
  mspu_result_if.source result_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  // Parser phase: where in a note the next character belongs.
  typedef enum logic [2:0] {
    PH_OCTAVE = 3'd0,
    PH_LETTER = 3'd1,
    PH_MOD    = 3'd2,
    PH_DUR    = 3'd3,
    PH_EFFECT = 3'd4
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [2:0] octave_q, octave_d;
  logic [3:0] note_q, note_d;
  logic [2:0] dur_q, dur_d;

  // Result queue.
  result_t           queue_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   count_q;

  logic       accept;
  logic       pop;
  logic [7:0] c;
  logic [7:0] u;
  logic [1:0] n_res;
  result_t    res0, res1;

  // Note code for a held octave and note: 24 per octave above 2, 2 per semitone.
  function automatic logic [7:0] note_code_f(input logic [2:0] oct, input logic [3:0] nt);
    logic [7:0] oct_off;
    logic [7:0] nt_off;
    oct_off = {5'b0, oct} - 8'd2;
    nt_off  = {4'b0, nt} - 8'd1;
    if (nt == NOTE_PAUSE) begin
      note_code_f = PAUSE_CODE;
    end else if (oct < 3'd2 || nt < NOTE_C || nt > NOTE_B) begin
      note_code_f = 8'd0;
    end else begin
      note_code_f = 8'(oct_off * OCTAVE_STEP) + 8'(nt_off << 1);
    end
  endfunction

  function automatic result_t flag_result(input logic [1:0] kind);
    result_t r;
    r.kind       = kind;
    r.param_byte = 8'd0;
    r.note_code  = 8'd0;
    r.last       = 1'b0;
    return r;
  endfunction

  // The queue always keeps room for two results of the next character.
  assign char_i.ready = (count_q <= CntW'(Depth - 2));
  assign accept       = char_i.valid && char_i.ready;
  assign pop          = result_o.valid && result_o.ready;

  assign c = char_i.char_in;
  assign u = (c inside {["a":"z"]}) ? c - 8'd32 : c;

  // Decode one character against the current phase.
  always_comb begin
    result_t note_res;
    logic [1:0] effect;
    phase_d  = phase_q;
    octave_d = octave_q;
    note_d   = note_q;
    dur_d    = dur_q;
    n_res    = 2'd0;
    res0     = flag_result(KIND_ERROR);
    res1     = flag_result(KIND_ERROR);
    effect   = EFFECT_NONE;

    note_res            = flag_result(KIND_NOTE);
    note_res.note_code  = note_code_f(octave_q, note_q);

    case (phase_q)
      PH_LETTER: begin
        phase_d = PH_MOD;
        case (u)
          "C": note_d = NOTE_C;
          "D": begin note_d = NOTE_D; phase_d = PH_DUR; end
          "E": note_d = NOTE_E;
          "F": note_d = NOTE_F;
          "G": note_d = NOTE_G;
          "A": begin note_d = NOTE_A; phase_d = PH_DUR; end
          "B": note_d = NOTE_B;
          "P": begin note_d = NOTE_PAUSE; phase_d = PH_DUR; end
          default: begin
            note_d  = note_q;
            phase_d = PH_OCTAVE;
            n_res   = 2'd1;
          end
        endcase
      end
      PH_MOD, PH_DUR: begin
        if (phase_q == PH_MOD && (note_q == NOTE_C || note_q == NOTE_F ||
            note_q == NOTE_G) && c == "#") begin
          note_d  = note_q + 4'd1;
          phase_d = PH_DUR;
        end else if (phase_q == PH_MOD && (note_q == NOTE_E || note_q == NOTE_B) &&
                     u == "B") begin
          note_d  = note_q - 4'd1;
          phase_d = PH_DUR;
        end else if (c inside {["1":"8"]}) begin
          dur_d   = 3'(c - 8'd49);
          phase_d = PH_EFFECT;
        end else begin
          phase_d = PH_OCTAVE;
          n_res   = 2'd1;
        end
      end
      PH_EFFECT: begin
        phase_d = PH_OCTAVE;
        if (c == "+" || c == "-" || c == "=") begin
          if (c == "+") begin
            effect = EFFECT_PLUS;
          end else if (c == "-") begin
            effect = EFFECT_MINUS;
          end else begin
            effect = EFFECT_EQUAL;
          end
          n_res = 2'd1;
        end else if (c inside {["2":"7"]}) begin
          // The note closes with no effect and this digit opens the next one.
          octave_d = 3'(c - 8'd48);
          phase_d  = PH_LETTER;
          n_res    = 2'd1;
        end else begin
          n_res = 2'd2;
          res1  = flag_result((c == "\"" || c == "'") ? KIND_END : KIND_ERROR);
        end
        note_res.param_byte = {effect, 3'b000, dur_q};
        res0 = note_res;
      end
      default: begin
        if (c inside {["2":"7"]}) begin
          octave_d = 3'(c - 8'd48);
          phase_d  = PH_LETTER;
        end else begin
          phase_d = PH_OCTAVE;
          n_res   = 2'd1;
          res0    = flag_result((c == "\"" || c == "'") ? KIND_END : KIND_ERROR);
        end
      end
    endcase

    if (n_res == 2'd2) begin
      res1.last = 1'b1;
    end else begin
      res0.last = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_OCTAVE;
      octave_q <= 3'd0;
      note_q   <= NOTE_NONE;
      dur_q    <= 3'd0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (accept) begin
        phase_q  <= phase_d;
        octave_q <= octave_d;
        note_q   <= note_d;
        dur_q    <= dur_d;
        wr_ptr_q <= wr_ptr_q + PtrW'(n_res);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      count_q <= count_q + (accept ? CntW'(n_res) : CntW'(0)) - (pop ? CntW'(1) : CntW'(0));
    end
  end

  // Queue payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (accept && n_res != 2'd0) begin
      queue_q[wr_ptr_q] <= res0;
    end
    if (accept && n_res == 2'd2) begin
      queue_q[wr_ptr_q + PtrW'(1)] <= res1;
    end
  end

  assign result_o.valid      = (count_q != '0);
  assign result_o.kind       = queue_q[rd_ptr_q].kind;
  assign result_o.param_byte = queue_q[rd_ptr_q].param_byte;
  assign result_o.note_code  = queue_q[rd_ptr_q].note_code;
  assign result_o.last       = queue_q[rd_ptr_q].last;

  `MSPU_ASSERT(a_queue_bound, count_q <= CntW'(Depth), "result queue overflow")
  `MSPU_ASSERT_NEXT(a_two_results, accept && n_res == 2'd2 && !pop,
                    count_q == $past(count_q) + CntW'(2), "two results not both queued")
  `MSPU_ASSERT_NEXT(a_effect_closes, accept && phase_q == PH_EFFECT,
                    phase_q == PH_OCTAVE || phase_q == PH_LETTER,
                    "note close left parser mid-note")
  `MSPU_ASSERT(a_flag_is_last, result_o.valid && result_o.kind != KIND_NOTE |-> result_o.last,
               "end or error result not marked last")

endmodule

`default_nettype wire
